@@ sv/ptb_pkg.sv @@
package ptb_pkg;

    localparam int MAX_TEXT    = 4096;
    localparam int ALPHABET    = 26;
    localparam int NODE_CAP    = MAX_TEXT + 2;
    localparam int CHILD_DEPTH = NODE_CAP * ALPHABET;

    localparam int LETTER_W = 5;
    localparam int FIELD_W  = 13;
    localparam int TEXT_AW  = $clog2(MAX_TEXT + 1);
    localparam int NODE_W   = $clog2(NODE_CAP);
    localparam int LEN_W    = NODE_W + 1;
    localparam int J_W      = LEN_W + 2;
    localparam int CHILD_AW = $clog2(CHILD_DEPTH);

    localparam logic [NODE_W-1:0] ROOT_EVEN = NODE_W'(0);
    localparam logic [NODE_W-1:0] ROOT_ODD  = NODE_W'(1);
    localparam logic [NODE_W-1:0] NODE_NONE = NODE_W'(0);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_WAIT  = 11'b00000000100,
        ST_JCALC = 11'b00000001000,
        ST_CMP   = 11'b00000010000,
        ST_CADDR = 11'b00000100000,
        ST_CRD   = 11'b00001000000,
        ST_CCHK  = 11'b00010000000,
        ST_NODE  = 11'b00100000000,
        ST_FIN   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

endpackage

@@ sv/palindromic_tree_builder.sv @@
// Online palindromic tree (eertree) over a stream of letters 0..25.
// Input channel s_valid/s_ready/s_letter: one letter per transaction.
// Result channel m_valid/m_ready: one result transaction per letter with the
// node of the longest palindromic suffix, its length, the number of
// palindromic suffixes ending at this position, a created flag and an
// overflow flag (text store full, letter dropped).
// Each suffix-link step reads the node, then the text letter if its index is
// in range, and compares; then come the child lookup (address, read, check)
// and the node fetch. A letter that creates a node runs a second suffix-link
// walk and child lookup to find the new node's link. The total number of
// suffix-link steps is amortized to a small constant per letter.
// A dropped letter (out of range or store full) goes straight to output.
// s_ready is high only while no letter is in progress; one letter is worked
// on at a time. A finished result waits in the output register while the
// next letter is accepted; if the receiver stalls, the following letter
// holds before writing its result until the register is free.
// After reset the child table is cleared one entry per cycle, s_ready low;
// control registers reset at once, data registers and other memories do not.
module palindromic_tree_builder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ptb_pkg::LETTER_W-1:0]  s_letter,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ptb_pkg::FIELD_W-1:0]   m_suffix_node,
    output logic [ptb_pkg::FIELD_W-1:0]   m_pal_length,
    output logic [ptb_pkg::FIELD_W-1:0]   m_pal_suffix_count,
    output logic                          m_created,
    output logic                          m_overflow
);
    import ptb_pkg::*;

    logic [4:0]                text_mem  [MAX_TEXT+1];
    logic [NODE_W-1:0]         link_mem  [NODE_CAP];
    logic signed [LEN_W-1:0]   len_mem   [NODE_CAP];
    logic [FIELD_W-1:0]        cnt_mem   [NODE_CAP];
    logic [NODE_W-1:0]         child_mem [CHILD_DEPTH];

    state_t                   state_reg, state_next;
    logic [CHILD_AW-1:0]      clr_reg, clr_next;
    logic [TEXT_AW-1:0]       text_len_reg, text_len_next;
    logic [NODE_W-1:0]        total_reg, total_next;
    logic [NODE_W-1:0]        last_reg, last_next;
    logic [LETTER_W-1:0]      c_reg, c_next;
    logic [TEXT_AW-1:0]       pos_reg, pos_next;
    logic [NODE_W-1:0]        x_reg, x_next;
    logic                     walk2_reg, walk2_next;
    logic [NODE_W-1:0]        p_reg, p_next;
    logic signed [LEN_W-1:0]  xlen_reg, xlen_next;
    logic [CHILD_AW-1:0]      ch_addr_reg, ch_addr_next;
    logic [CHILD_AW-1:0]      ch1_addr_reg, ch1_addr_next;

    logic [NODE_W-1:0]        nd_idx_reg;
    logic [NODE_W-1:0]        nd_link_reg;
    logic signed [LEN_W-1:0]  nd_len_reg;
    logic [FIELD_W-1:0]       nd_cnt_reg;
    logic [4:0]               txt_rd_reg;
    logic [NODE_W-1:0]        ch_rd_reg;

    logic                     m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]       res_node_reg, res_node_next;
    logic [FIELD_W-1:0]       res_len_reg, res_len_next;
    logic [FIELD_W-1:0]       res_cnt_reg, res_cnt_next;
    logic                     res_created_reg, res_created_next;
    logic                     res_overflow_reg, res_overflow_next;
    logic [FIELD_W-1:0]       out_node_reg, out_len_reg, out_cnt_reg;
    logic                     out_created_reg, out_overflow_reg;

    logic [NODE_W-1:0]        link_eff;
    logic signed [LEN_W-1:0]  len_eff;
    logic [FIELD_W-1:0]       cnt_eff;
    logic signed [J_W-1:0]    j_val;
    logic                     j_ok;
    logic [TEXT_AW-1:0]       j_idx;
    logic                     text_we;
    logic                     node_we;
    logic                     cnt_we;
    logic                     child_we;
    logic [CHILD_AW-1:0]      child_wa;
    logic [NODE_W-1:0]        child_wd;
    logic                     out_load;
    logic                     s_fire;

    assign s_ready            = (state_reg == ST_IDLE);
    assign s_fire             = s_valid && s_ready;
    assign m_valid            = m_valid_reg;
    assign m_suffix_node      = out_node_reg;
    assign m_pal_length       = out_len_reg;
    assign m_pal_suffix_count = out_cnt_reg;
    assign m_created          = out_created_reg;
    assign m_overflow         = out_overflow_reg;

    always_comb begin
        case (nd_idx_reg)
            ROOT_EVEN: begin
                link_eff = ROOT_ODD;
                len_eff  = LEN_W'(0);
                cnt_eff  = FIELD_W'(0);
            end
            ROOT_ODD: begin
                link_eff = ROOT_ODD;
                len_eff  = -LEN_W'(1);
                cnt_eff  = FIELD_W'(0);
            end
            default: begin
                link_eff = nd_link_reg;
                len_eff  = nd_len_reg;
                cnt_eff  = nd_cnt_reg;
            end
        endcase
    end

    assign j_val = $signed(J_W'(pos_reg)) - J_W'(len_eff) - J_W'(1);
    assign j_ok  = !j_val[J_W-1] && (j_val != J_W'(0));
    assign j_idx = j_val[TEXT_AW-1:0];

    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        text_len_next     = text_len_reg;
        total_next        = total_reg;
        last_next         = last_reg;
        c_next            = c_reg;
        pos_next          = pos_reg;
        x_next            = x_reg;
        walk2_next        = walk2_reg;
        p_next            = p_reg;
        xlen_next         = xlen_reg;
        ch_addr_next      = ch_addr_reg;
        ch1_addr_next     = ch1_addr_reg;
        res_node_next     = res_node_reg;
        res_len_next      = res_len_reg;
        res_cnt_next      = res_cnt_reg;
        res_created_next  = res_created_reg;
        res_overflow_next = res_overflow_reg;
        text_we           = 1'b0;
        node_we           = 1'b0;
        cnt_we            = 1'b0;
        child_we          = 1'b0;
        child_wa          = ch1_addr_reg;
        child_wd          = p_reg;
        out_load          = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;

        case (state_reg)
            ST_CLEAR: begin
                child_we = 1'b1;
                child_wa = clr_reg;
                child_wd = NODE_NONE;
                clr_next = clr_reg + CHILD_AW'(1);
                if (clr_reg == CHILD_AW'(CHILD_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    c_next            = s_letter;
                    res_node_next     = FIELD_W'(0);
                    res_len_next      = FIELD_W'(0);
                    res_cnt_next      = FIELD_W'(0);
                    res_created_next  = 1'b0;
                    res_overflow_next = 1'b0;
                    walk2_next        = 1'b0;
                    if (s_letter >= LETTER_W'(ALPHABET)) begin
                        state_next = ST_OUT;
                    end else if (text_len_reg == TEXT_AW'(MAX_TEXT)) begin
                        res_overflow_next = 1'b1;
                        state_next        = ST_OUT;
                    end else begin
                        text_we       = 1'b1;
                        text_len_next = text_len_reg + TEXT_AW'(1);
                        pos_next      = text_len_reg + TEXT_AW'(1);
                        x_next        = last_reg;
                        state_next    = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                state_next = ST_JCALC;
            end
            ST_JCALC: begin
                if (j_ok) begin
                    state_next = ST_CMP;
                end else if (x_reg == ROOT_ODD) begin
                    state_next = ST_CADDR;
                end else begin
                    x_next     = link_eff;
                    state_next = ST_WAIT;
                end
            end
            ST_CMP: begin
                if (txt_rd_reg == c_reg || x_reg == ROOT_ODD) begin
                    state_next = ST_CADDR;
                end else begin
                    x_next     = link_eff;
                    state_next = ST_WAIT;
                end
            end
            ST_CADDR: begin
                ch_addr_next = CHILD_AW'(x_reg * ALPHABET + c_reg);
                state_next   = ST_CRD;
            end
            ST_CRD: begin
                state_next = ST_CCHK;
            end
            ST_CCHK: begin
                if (walk2_reg) begin
                    node_we    = 1'b1;
                    x_next     = ch_rd_reg;
                    state_next = ST_NODE;
                end else if (ch_rd_reg == NODE_NONE && total_reg < NODE_W'(NODE_CAP)) begin
                    p_next        = total_reg;
                    total_next    = total_reg + NODE_W'(1);
                    xlen_next     = len_eff;
                    ch1_addr_next = ch_addr_reg;
                    walk2_next    = 1'b1;
                    x_next        = link_eff;
                    state_next    = ST_WAIT;
                end else begin
                    x_next     = ch_rd_reg;
                    state_next = ST_NODE;
                end
            end
            ST_NODE: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (walk2_reg) begin
                    cnt_we           = 1'b1;
                    child_we         = 1'b1;
                    last_next        = p_reg;
                    res_node_next    = FIELD_W'(p_reg);
                    res_len_next     = FIELD_W'(xlen_reg + LEN_W'(2));
                    res_cnt_next     = cnt_eff + FIELD_W'(1);
                    res_created_next = 1'b1;
                end else begin
                    last_next     = x_reg;
                    res_node_next = FIELD_W'(x_reg);
                    res_len_next  = len_eff[LEN_W-1] ? FIELD_W'(0) : FIELD_W'(len_eff);
                    res_cnt_next  = cnt_eff;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= CHILD_AW'(0);
            text_len_reg <= TEXT_AW'(0);
            total_reg    <= NODE_W'(2);
            last_reg     <= ROOT_EVEN;
            walk2_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            text_len_reg <= text_len_next;
            total_reg    <= total_next;
            last_reg     <= last_next;
            walk2_reg    <= walk2_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg            <= c_next;
        pos_reg          <= pos_next;
        x_reg            <= x_next;
        p_reg            <= p_next;
        xlen_reg         <= xlen_next;
        ch_addr_reg      <= ch_addr_next;
        ch1_addr_reg     <= ch1_addr_next;
        res_node_reg     <= res_node_next;
        res_len_reg      <= res_len_next;
        res_cnt_reg      <= res_cnt_next;
        res_created_reg  <= res_created_next;
        res_overflow_reg <= res_overflow_next;
        if (out_load) begin
            out_node_reg     <= res_node_reg;
            out_len_reg      <= res_len_reg;
            out_cnt_reg      <= res_cnt_reg;
            out_created_reg  <= res_created_reg;
            out_overflow_reg <= res_overflow_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (text_we) begin
            text_mem[pos_next] <= s_letter;
        end
        txt_rd_reg <= text_mem[j_idx];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            len_mem[p_reg]  <= xlen_reg + LEN_W'(2);
            link_mem[p_reg] <= ch_rd_reg;
        end
        if (cnt_we) begin
            cnt_mem[p_reg] <= cnt_eff + FIELD_W'(1);
        end
        nd_idx_reg  <= x_reg;
        nd_link_reg <= link_mem[x_reg];
        nd_len_reg  <= len_mem[x_reg];
        nd_cnt_reg  <= cnt_mem[x_reg];
    end

    always_ff @(posedge aclk) begin
        if (child_we) begin
            child_mem[child_wa] <= child_wd;
        end
        ch_rd_reg <= child_mem[ch_addr_reg];
    end

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int LETTER_MAX     = 2**LETTER_W - 1;
    localparam int RANDOM_LETTERS = 680;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 600000;
    localparam int PRINT_CAP      = 60;

    typedef struct packed {
        logic [FIELD_W-1:0] suffix_node;
        logic [FIELD_W-1:0] pal_length;
        logic [FIELD_W-1:0] pal_suffix_count;
        logic               created;
        logic               overflow;
    } pal_report_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [LETTER_W-1:0] s_letter = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [FIELD_W-1:0]  m_suffix_node;
    logic [FIELD_W-1:0]  m_pal_length;
    logic [FIELD_W-1:0]  m_pal_suffix_count;
    logic                m_created;
    logic                m_overflow;

    palindromic_tree_builder DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_letter           (s_letter),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_suffix_node      (m_suffix_node),
        .m_pal_length       (m_pal_length),
        .m_pal_suffix_count (m_pal_suffix_count),
        .m_created          (m_created),
        .m_overflow         (m_overflow)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Tree model state
    logic [LETTER_W-1:0]      txt [0:MAX_TEXT];
    logic [TEXT_AW-1:0]       txt_len;
    logic [NODE_W-1:0]        node_link_tab [NODE_CAP];
    logic signed [LEN_W-1:0]  node_len_tab [NODE_CAP];
    logic [FIELD_W-1:0]       node_count_tab [NODE_CAP];
    logic [NODE_W-1:0]        kids [CHILD_DEPTH];
    logic [NODE_W-1:0]        node_total;
    logic [NODE_W-1:0]        tail_node;

    logic [LETTER_W-1:0] letter_queue [$];
    pal_report_t         pal_reports [$];
    int                  gen_text [0:MAX_TEXT];
    int                  gen_len = 0;

    int mismatches = 0;
    int total_letters = 0;
    int sent_count = 0;
    int ignored_count = 0;
    int checked_count = 0;
    int created_count = 0;
    int overflow_count = 0;
    int longest_seen = 0;
    int gap_left = 0;
    int stall_left = 0;
    int stall_draw = 0;
    int idle_cycles = 0;
    pal_report_t want;

    task automatic report_error(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void tree_clear();
        foreach (kids[i]) kids[i] = NODE_NONE;
        foreach (node_link_tab[i]) begin
            node_link_tab[i] = NODE_NONE;
            node_len_tab[i] = '0;
            node_count_tab[i] = '0;
        end
        foreach (txt[i]) txt[i] = '0;
        node_link_tab[ROOT_EVEN] = ROOT_ODD;
        node_link_tab[ROOT_ODD] = ROOT_ODD;
        node_len_tab[ROOT_ODD] = -LEN_W'(1);
        node_total = NODE_W'(2);
        tail_node = ROOT_EVEN;
        txt_len = '0;
    endfunction

    function automatic logic [NODE_W-1:0] walk_links(logic [NODE_W-1:0] x, int pos);
        int j;
        for (int steps = 0; steps <= NODE_CAP + 1; steps++) begin
            j = pos - node_len_tab[x] - 1;
            if (j >= 1 && txt[j] == txt[pos])
                return x;
            if (x == ROOT_ODD)
                return ROOT_ODD;
            x = node_link_tab[x];
        end
        return ROOT_ODD;
    endfunction

    function automatic pal_report_t extend_tree(logic [LETTER_W-1:0] c);
        pal_report_t r;
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] f;
        logic [NODE_W-1:0] lk;
        logic [NODE_W-1:0] p;
        logic [NODE_W-1:0] nd;
        int unsigned ci;
        int pos;
        r = '0;
        if (c >= ALPHABET)
            return r;
        if (txt_len >= MAX_TEXT) begin
            r.overflow = 1'b1;
            return r;
        end
        txt_len++;
        pos = int'(txt_len);
        txt[pos] = c;
        x = walk_links(tail_node, pos);
        ci = int'(x) * ALPHABET + int'(c);
        if (kids[ci] == NODE_NONE && node_total < NODE_CAP) begin
            p = node_total;
            node_total++;
            f = walk_links(node_link_tab[x], pos);
            lk = kids[int'(f) * ALPHABET + int'(c)];
            node_len_tab[p] = node_len_tab[x] + LEN_W'(2);
            node_link_tab[p] = lk;
            node_count_tab[p] = node_count_tab[lk] + 1'b1;
            kids[ci] = p;
            r.created = 1'b1;
        end
        nd = kids[ci];
        tail_node = nd;
        r.suffix_node = FIELD_W'(nd);
        r.pal_length = (node_len_tab[nd] < 0) ? '0 : FIELD_W'(node_len_tab[nd]);
        r.pal_suffix_count = node_count_tab[nd];
        return r;
    endfunction

    task automatic add_letter(input int c);
        letter_queue.insert(letter_queue.size(), LETTER_W'(c));
        if (c < ALPHABET && gen_len < MAX_TEXT) begin
            gen_len++;
            gen_text[gen_len] = c;
        end
    endtask

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_letter <= '0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                pal_reports.insert(pal_reports.size(), extend_tree(s_letter));
                sent_count++;
                if (s_letter >= ALPHABET)
                    ignored_count++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (letter_queue.size() != 0) begin
                    s_valid <= 1'b1;
                    s_letter <= letter_queue.pop_front();
                    gap_left <= ((sent_count / 97) % 3 == 0) ? 0 : $urandom_range(0, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                checked_count++;
                if (pal_reports.size() == 0) begin
                    report_error($sformatf("result with no letter pending, node %0d",
                                           m_suffix_node));
                end else begin
                    want = pal_reports.pop_front();
                    if (m_suffix_node !== want.suffix_node)
                        report_error($sformatf("suffix_node got %0d want %0d",
                                               m_suffix_node, want.suffix_node));
                    if (m_pal_length !== want.pal_length)
                        report_error($sformatf("pal_length got %0d want %0d",
                                               m_pal_length, want.pal_length));
                    if (m_pal_suffix_count !== want.pal_suffix_count)
                        report_error($sformatf("pal_suffix_count got %0d want %0d",
                                               m_pal_suffix_count, want.pal_suffix_count));
                    if (m_created !== want.created)
                        report_error($sformatf("created got %0b want %0b",
                                               m_created, want.created));
                    if (m_overflow !== want.overflow)
                        report_error($sformatf("overflow got %0b want %0b",
                                               m_overflow, want.overflow));
                    if (want.created)
                        created_count++;
                    if (want.overflow)
                        overflow_count++;
                    if (int'(want.pal_length) > longest_seen)
                        longest_seen = int'(want.pal_length);
                end
                stall_draw = ((checked_count / 151) % 4 == 1) ? 0 : $urandom_range(0, 4);
                stall_left <= stall_draw;
                m_ready <= (stall_draw == 0);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready <= (stall_left == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("tb: watchdog expired, %0d letters in, %0d results out",
                         sent_count, checked_count);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int opening [$];
        int kind;
        int span;
        int base;
        int width;
        int reps;
        int top;
        int c;
        int half [32];
        int word [8];
        tree_clear();

        opening = '{LETTER_MAX, 0, 0, 0, 1, 0, 0, ALPHABET, ALPHABET - 1, ALPHABET - 1,
                    0, 0, 1, 0, 0, 16, 2, 16, 0, 0, 1, 15, 30};
        foreach (opening[i]) add_letter(opening[i]);

        while (gen_len < RANDOM_LETTERS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    width = $urandom_range(2, 4);
                    base = $urandom_range(0, ALPHABET - width);
                    span = $urandom_range(1, 20);
                    for (int i = 0; i < span; i++) half[i] = base + $urandom_range(0, width - 1);
                    for (int i = 0; i < span; i++) add_letter(half[i]);
                    if ($urandom_range(0, 1))
                        add_letter(base + $urandom_range(0, width - 1));
                    for (int i = span - 1; i >= 0; i--) add_letter(half[i]);
                end
                3, 4: begin
                    c = $urandom_range(0, ALPHABET - 1);
                    reps = $urandom_range(1, 30);
                    for (int i = 0; i < reps; i++) add_letter(c);
                end
                5: begin
                    top = gen_len;
                    span = $urandom_range(1, 60);
                    if (span > top)
                        span = top;
                    for (int i = 0; i < span; i++) add_letter(gen_text[top - i]);
                end
                6, 7: begin
                    base = $urandom_range(0, ALPHABET - 2);
                    span = $urandom_range(1, 20);
                    for (int i = 0; i < span; i++) add_letter(base + $urandom_range(0, 1));
                end
                8: begin
                    span = $urandom_range(1, 8);
                    for (int i = 0; i < span; i++) add_letter($urandom_range(0, LETTER_MAX));
                end
                default: begin
                    width = $urandom_range(2, 5);
                    base = $urandom_range(0, ALPHABET - 3);
                    for (int i = 0; i < width; i++) word[i] = base + $urandom_range(0, 2);
                    reps = $urandom_range(2, 8);
                    for (int k = 0; k < reps; k++)
                        for (int i = 0; i < width; i++) add_letter(word[i]);
                end
            endcase
        end

        // mirror the whole text, then add a short tail of edge letters
        top = gen_len;
        for (int i = top; i >= 1; i--) add_letter(gen_text[i]);
        add_letter(0);
        add_letter(ALPHABET - 1);
        add_letter(LETTER_MAX);
        add_letter(16);
        add_letter(ALPHABET);
        add_letter($urandom_range(0, ALPHABET - 1));
        total_letters = letter_queue.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (sent_count < total_letters || pal_reports.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("tb: %0d letters sent (%0d out of alphabet), %0d results checked",
                 sent_count, ignored_count, checked_count);
        $display("tb: %0d nodes created, %0d overflow results, longest palindrome %0d",
                 created_count, overflow_count, longest_seen);
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
